### rtl/motion_to_arrow_key_converter_unit_assert.svh
// ----------------------------------------------------------------------------
// Motion-to-arrow converter assertion macros
// Shared concurrent assertion helpers for the checker.
// ----------------------------------------------------------------------------
`ifndef MOTION_TO_ARROW_KEY_CONVERTER_UNIT_ASSERT_SVH
`define MOTION_TO_ARROW_KEY_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication
`define MTAK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mtak assertion failed");

// next-cycle implication
`define MTAK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mtak assertion failed");

`endif

### rtl/mtak_pkg.sv
// ----------------------------------------------------------------------------
// mtak_pkg
// Types and constants shared by the motion-to-arrow converter.
// ----------------------------------------------------------------------------
package mtak_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [PADDR_W-3:0] REG_STEP_FACTOR = 1'b0;

  localparam logic [7:0] STEP_FACTOR_RESET = 8'd24;
  localparam logic [7:0] MIN_FACTOR        = 8'd4;
  localparam logic [5:0] TAP_CAP           = 6'd63;

  localparam logic [1:0] KIND_MOTION = 2'd0;
  localparam logic [1:0] KIND_TAP    = 2'd1;
  localparam logic [1:0] KIND_ACK    = 2'd2;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef struct packed {
    logic load;
    logic ack;
    logic pass;
    logic accum;
    logic start;
    logic tap;
    logic zero_other;
    logic final_rpt;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic mode;
    logic over;
    logic tap_ok;
    logic out_free;
  } stat_t;

endpackage

### rtl/mtak_ctrl.sv
// ----------------------------------------------------------------------------
// mtak_ctrl
// Sequencer: decodes the item; ack, pass or accumulate, tap loop, final report.
// ----------------------------------------------------------------------------
module mtak_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mtak_pkg::stat_t stat_i,
  output mtak_pkg::cmd_t  cmd_o
);
  import mtak_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVAL  = 5'b00010,
    ST_START = 5'b00100,
    ST_TAP   = 5'b01000,
    ST_FINAL = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat_i.action) begin
          if (stat_i.out_free) begin
            cmd_o.ack = 1'b1;
            state_d   = ST_IDLE;
          end
        end else if (!stat_i.mode) begin
          if (stat_i.out_free) begin
            cmd_o.pass = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          cmd_o.accum = 1'b1;
          state_d     = ST_START;
        end
      end
      ST_START: begin
        if (stat_i.over) begin
          cmd_o.start = 1'b1;
          state_d     = ST_TAP;
        end else begin
          state_d = ST_FINAL;
        end
      end
      ST_TAP: begin
        // bound is re-evaluated from the updated accumulators each tap
        if (stat_i.tap_ok) begin
          if (stat_i.out_free) cmd_o.tap = 1'b1;
        end else begin
          cmd_o.zero_other = 1'b1;
          state_d          = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (stat_i.out_free) begin
          cmd_o.final_rpt = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/mtak_dp.sv
// ----------------------------------------------------------------------------
// mtak_dp
// Accumulators, tap counter, running bound product and output register.
// ----------------------------------------------------------------------------
module mtak_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mtak_pkg::cmd_t    cmd_i,
  output mtak_pkg::stat_t   stat_o,
  input  logic [7:0]        step_factor_i,
  input  logic              action_i,
  input  logic signed [7:0] delta_x_i,
  input  logic signed [7:0] delta_y_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [1:0]        direction_o,
  output logic signed [7:0] report_x_o,
  output logic signed [7:0] report_y_o,
  output logic              arrow_mode_o,
  output logic              last_o
);
  import mtak_pkg::*;

  logic              action_q;
  logic [7:0]        dx_q, dy_q;
  logic              mode_q;
  logic [9:0]        ax_q, ax_d, ay_q, ay_d;
  logic [1:0]        dir_q;
  logic              horiz_q;
  logic [5:0]        cnt_q;
  logic [13:0]       prod_q;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        kind_q, dir_out_q;
  logic [7:0]        rx_q, ry_q;
  logic              mode_out_q, last_q;

  logic [7:0]        fac;
  logic [9:0]        abs_x, abs_y;
  logic [10:0]       sum;
  logic [10:0]       sx, sy;
  logic [9:0]        sat_x, sat_y;
  logic [10:0]       x_m, x_p, y_m, y_p;
  logic              ax_pos, ay_pos, horiz;
  logic [1:0]        dir_new;
  logic              emit;

  assign fac   = (step_factor_i < MIN_FACTOR) ? MIN_FACTOR : step_factor_i;
  assign abs_x = ax_q[9] ? 10'(-ax_q) : ax_q;
  assign abs_y = ay_q[9] ? 10'(-ay_q) : ay_q;
  assign sum   = {1'b0, abs_x} + {1'b0, abs_y};

  // saturating add of the deltas
  assign sx = {ax_q[9], ax_q} + {{3{dx_q[7]}}, dx_q};
  assign sy = {ay_q[9], ay_q} + {{3{dy_q[7]}}, dy_q};
  always_comb begin
    case (sx[10:9])
      2'b01:   sat_x = 10'h1FF;
      2'b10:   sat_x = 10'h200;
      default: sat_x = sx[9:0];
    endcase
    case (sy[10:9])
      2'b01:   sat_y = 10'h1FF;
      2'b10:   sat_y = 10'h200;
      default: sat_y = sy[9:0];
    endcase
  end

  assign x_m = {ax_q[9], ax_q} - {3'b0, fac};
  assign x_p = {ax_q[9], ax_q} + {3'b0, fac};
  assign y_m = {ay_q[9], ay_q} - {3'b0, fac};
  assign y_p = {ay_q[9], ay_q} + {3'b0, fac};

  assign ax_pos  = !ax_q[9] && (ax_q != '0);
  assign ay_pos  = !ay_q[9] && (ay_q != '0);
  assign horiz   = abs_x > abs_y;
  assign dir_new = horiz ? (ax_pos ? DIR_RIGHT : DIR_LEFT)
                         : (ay_pos ? DIR_DOWN : DIR_UP);

  assign stat_o.action   = action_q;
  assign stat_o.mode     = mode_q;
  assign stat_o.over     = sum >= {3'b0, fac};
  // tap i allowed while i < 63 and i*fac <= |x|+|y|
  assign stat_o.tap_ok   = (cnt_q != TAP_CAP) && ({3'b0, sum} >= prod_q);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    ax_d = ax_q;
    ay_d = ay_q;
    if (cmd_i.accum) begin
      ax_d = sat_x;
      ay_d = sat_y;
    end else if (cmd_i.tap) begin
      case (dir_q)
        DIR_RIGHT: ax_d = (!x_m[10] && x_m != '0) ? x_m[9:0] : '0;
        DIR_LEFT:  ax_d = x_p[10] ? x_p[9:0] : '0;
        DIR_DOWN:  ay_d = (!y_m[10] && y_m != '0) ? y_m[9:0] : '0;
        default:   ay_d = y_p[10] ? y_p[9:0] : '0;
      endcase
    end else if (cmd_i.zero_other) begin
      if (horiz_q) ay_d = '0;
      else         ax_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      ax_q   <= '0;
      ay_q   <= '0;
    end else begin
      if (cmd_i.ack) mode_q <= !mode_q;
      ax_q <= ax_d;
      ay_q <= ay_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      dx_q     <= delta_x_i;
      dy_q     <= delta_y_i;
    end
    if (cmd_i.start) begin
      dir_q   <= dir_new;
      horiz_q <= horiz;
      cnt_q   <= '0;
      prod_q  <= '0;
    end else if (cmd_i.tap) begin
      cnt_q  <= cnt_q + 6'd1;
      prod_q <= prod_q + {6'b0, fac};
    end
  end

  // output register
  assign emit        = cmd_i.ack || cmd_i.pass || cmd_i.tap || cmd_i.final_rpt;
  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q     <= KIND_MOTION;
      dir_out_q  <= DIR_RIGHT;
      rx_q       <= '0;
      ry_q       <= '0;
      mode_out_q <= mode_q;
      last_q     <= 1'b1;
      if (cmd_i.ack) begin
        kind_q     <= KIND_ACK;
        mode_out_q <= !mode_q;
      end else if (cmd_i.pass) begin
        rx_q <= dx_q;
        ry_q <= dy_q;
      end else if (cmd_i.tap) begin
        kind_q    <= KIND_TAP;
        dir_out_q <= dir_q;
        last_q    <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign direction_o  = dir_out_q;
  assign report_x_o   = rx_q;
  assign report_y_o   = ry_q;
  assign arrow_mode_o = mode_out_q;
  assign last_o       = last_q;

endmodule

### rtl/motion_to_arrow_key_converter_unit.sv
// ----------------------------------------------------------------------------
// motion_to_arrow_key_converter_unit
// Turns pointer motion into arrow taps in arrow mode, else passes it through.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     in_valid_i / in_stall_o    action_i, delta_x_i, delta_y_i
//  output    out_valid_o / out_stall_i  kind_o, direction_o, report_x_o,
//                                       report_y_o, arrow_mode_o, last_o
//  config    APB (psel..pready)         step_factor at byte address 0
//
//  One item at a time. Arrow mode gives N taps (N <= 63), one result per
//  cycle from the tap loop of the sequencer while the output is not stalled.
//  Output stall holds the sequencer in place; input is stalled until the
//  item's last result is loaded into the output register.
//  Reset clears arrow mode, accumulators and sets step_factor to 24.
// ----------------------------------------------------------------------------
module motion_to_arrow_key_converter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtak_pkg::PADDR_W-1:0]  paddr,
  input  logic [mtak_pkg::PDATA_W-1:0]  pwdata,
  output logic [mtak_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic signed [7:0]             delta_x_i,
  input  logic signed [7:0]             delta_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [1:0]                    direction_o,
  output logic signed [7:0]             report_x_o,
  output logic signed [7:0]             report_y_o,
  output logic                          arrow_mode_o,
  output logic                          last_o
);
  import mtak_pkg::*;

  logic [7:0] step_factor_q;
  logic       sel_step;
  cmd_t       cmd;
  stat_t      stat;

  assign pready   = 1'b1;
  assign sel_step = (paddr[PADDR_W-1:2] == REG_STEP_FACTOR);
  assign prdata   = sel_step ? {{(PDATA_W-8){1'b0}}, step_factor_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_factor_q <= STEP_FACTOR_RESET;
    end else if (psel && penable && pwrite && pready && sel_step) begin
      step_factor_q <= pwdata[7:0];
    end
  end

  mtak_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mtak_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .step_factor_i (step_factor_q),
    .action_i      (action_i),
    .delta_x_i     (delta_x_i),
    .delta_y_i     (delta_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .direction_o   (direction_o),
    .report_x_o    (report_x_o),
    .report_y_o    (report_y_o),
    .arrow_mode_o  (arrow_mode_o),
    .last_o        (last_o)
  );

endmodule

### rtl/mtak_checker.sv
// ----------------------------------------------------------------------------
// mtak_checker
// Port-level checks for the motion-to-arrow converter, bound to the top.
// ----------------------------------------------------------------------------
`include "motion_to_arrow_key_converter_unit_assert.svh"

module mtak_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        kind_o,
  input logic [1:0]        direction_o,
  input logic signed [7:0] report_x_o,
  input logic signed [7:0] report_y_o,
  input logic              arrow_mode_o,
  input logic              last_o
);
  import mtak_pkg::*;

  logic        out_wait;
  logic        tap_out;
  logic        ack_out;
  logic        no_motion;
  logic [21:0] out_word;

  assign out_wait  = out_valid_o && out_stall_i;
  assign tap_out   = out_valid_o && (kind_o == KIND_TAP);
  assign ack_out   = out_valid_o && (kind_o == KIND_ACK);
  assign no_motion = (report_x_o == 8'sd0) && (report_y_o == 8'sd0);
  assign out_word  = {kind_o, direction_o, report_x_o, report_y_o, arrow_mode_o, last_o};

  // stalled result holds
  `MTAK_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_word))
  // taps are never last and carry no motion
  `MTAK_ASSERT_NOW(a_tap_shape, clk_i, rst_ni, tap_out, !last_o && no_motion && arrow_mode_o)
  // acknowledge is a single result
  `MTAK_ASSERT_NOW(a_ack_shape, clk_i, rst_ni, ack_out, last_o && no_motion && direction_o == DIR_RIGHT)
  // one item at a time: busy right after a transfer in
  `MTAK_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind motion_to_arrow_key_converter_unit mtak_checker u_mtak_checker (.*);
